// ===== rtl/lightmap_atlas_allocator_macros.svh =====
// Assertion macros for the lightmap atlas allocator.
// Used by the top level; expects clk and arst_n in scope.
`ifndef LIGHTMAP_ATLAS_ALLOCATOR_MACROS_SVH
`define LIGHTMAP_ATLAS_ALLOCATOR_MACROS_SVH

// invariant checked at every edge
`define LMA_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication
`define LMA_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LMA_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lma_pkg.sv =====
// Shared types and constants of the lightmap atlas allocator.
// No dependencies.
package lma_pkg;

	localparam int BLOCK_SHIFT = 4;
	localparam int EXT_W       = 11;
	localparam int OUT_W       = 7;
	localparam int DIM_W       = 8;
	localparam int SZ_W        = 12;

	typedef enum logic [1:0] {
		ST_PLACED    = 2'd0,
		ST_SKIPPED   = 2'd1,
		ST_EXHAUSTED = 2'd2,
		ST_TOO_BIG   = 2'd3
	} lma_status_t;

	typedef struct packed {
		logic [EXT_W-1:0] extent_s;
		logic [EXT_W-1:0] extent_t;
		logic             skip;
	} lma_req_t;

	typedef struct packed {
		lma_status_t      status;
		logic [OUT_W-1:0] x_pos;
		logic [OUT_W-1:0] y_pos;
		logic [OUT_W-1:0] page;
	} lma_res_t;

	typedef struct packed {
		logic clear;
		logic valid;
		logic last;
	} scan_ctl_t;

	typedef struct packed {
		logic done;
		logic found;
	} scan_stat_t;

endpackage

// ===== rtl/lma_sky.sv =====
// Skyline column height memory: one write port, one registered read port.
// Depends on nothing.
module lma_sky #(
	parameter int DEPTH = 128,
	parameter int AW    = 7,
	parameter int DW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/lma_scan.sv =====
// Window test unit: streams column heights and finds the leftmost run of
// span columns at or below a level. Depends on lma_pkg.
module lma_scan import lma_pkg::*; #(
	parameter int XW = 7,
	parameter int HW = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  scan_ctl_t        ctl,
	input  logic [HW-1:0]    rd_data,
	input  logic [XW-1:0]    rd_idx,
	input  logic [HW-1:0]    level,
	input  logic [DIM_W-1:0] span,
	output scan_stat_t       stat,
	output logic [XW-1:0]    pos
);

	logic [DIM_W-1:0] run_q;
	scan_stat_t       stat_q;
	logic [XW-1:0]    pos_q;
	logic             hit;
	logic             complete;

	always_comb begin
		hit      = (rd_data <= level);
		complete = hit && ((run_q + DIM_W'(1)) == span);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= '0;
			stat_q <= '0;
			pos_q  <= '0;
		end else if (ctl.clear) begin
			run_q  <= '0;
			stat_q <= '0;
		end else if (ctl.valid && !stat_q.done) begin
			run_q <= hit ? run_q + DIM_W'(1) : '0;
			if (complete) begin
				stat_q <= '{done: 1'b1, found: 1'b1};
				pos_q  <= XW'(SZ_W'(rd_idx) + SZ_W'(1) - SZ_W'(span));
			end else if (ctl.last) begin
				stat_q <= '{done: 1'b1, found: 1'b0};
			end
		end
	end

	assign stat = stat_q;
	assign pos  = pos_q;

endmodule

// ===== rtl/lightmap_atlas_allocator.sv =====
// Skipped surface: result registered at the accepting edge. Placement: a probe pass at the
// highest usable level, then a binary search on the level, each pass streaming the columns
// through one compare unit fed by one memory read port; at most clog2(ATLAS_HEIGHT)+1 passes,
// then w column writes, or a rewrite of all ATLAS_WIDTH columns when a new page is opened.
// One item at a time; busy is high while it works. After reset the skyline is cleared by a sweep
// of all ATLAS_WIDTH columns with busy high. Results are one-cycle strobes and cannot be held off.
`include "lightmap_atlas_allocator_macros.svh"
module lightmap_atlas_allocator import lma_pkg::*; #(
	parameter int ATLAS_WIDTH  = 128,
	parameter int ATLAS_HEIGHT = 128,
	parameter int PAGE_COUNT   = 128
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  lma_req_t req,
	output logic     done,
	output lma_res_t result
);

	localparam int XW = $clog2(ATLAS_WIDTH);
	localparam int HW = $clog2(ATLAS_HEIGHT + 1);
	localparam int PW = $clog2(PAGE_COUNT);
	localparam logic [XW-1:0] X_LAST     = XW'(ATLAS_WIDTH - 1);
	localparam logic [XW-1:0] X_SCAN_END = XW'(ATLAS_WIDTH - 2);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_CHECK, S_TEST, S_NEXT, S_FAIL, S_RAISE, S_PAGE
	} state_t;

	state_t           state_q;
	logic [PW-1:0]    page_q;
	logic [DIM_W-1:0] w_q;
	logic [DIM_W-1:0] h_q;
	logic [HW-1:0]    lo_q;
	logic [HW-1:0]    hi_q;
	logic [HW-1:0]    lvl_q;
	logic             probe_q;
	logic [XW-1:0]    bx_q;
	logic [XW-1:0]    addr_q;
	logic [DIM_W-1:0] cnt_q;
	logic             rd_end_q;
	logic             vld_s1;
	logic [XW-1:0]    idx_s1;
	logic             done_q;
	lma_res_t         result_q;

	logic             mem_we;
	logic [XW-1:0]    mem_waddr;
	logic [HW-1:0]    mem_wdata;
	logic [HW-1:0]    mem_rdata;
	scan_ctl_t        scan_ctl;
	scan_stat_t       scan_stat;
	logic [XW-1:0]    scan_pos;
	logic             fits_dims;
	logic             pages_out;
	logic [HW-1:0]    mid;

	always_comb begin
		fits_dims = (SZ_W'(w_q) < SZ_W'(ATLAS_WIDTH)) && (SZ_W'(h_q) <= SZ_W'(ATLAS_HEIGHT));
		pages_out = (SZ_W'(page_q) + SZ_W'(1)) >= SZ_W'(PAGE_COUNT);
		mid       = HW'((SZ_W'(lo_q) + SZ_W'(hi_q)) >> 1);
		scan_ctl  = '{clear: (state_q != S_TEST), valid: vld_s1, last: (idx_s1 == X_SCAN_END)};
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_PAGE: begin
				mem_we    = 1'b1;
				mem_wdata = (SZ_W'(addr_q) < SZ_W'(w_q)) ? HW'(h_q) : '0;
			end
			S_RAISE: begin
				mem_we    = 1'b1;
				mem_waddr = bx_q + XW'(cnt_q);
				mem_wdata = HW'(SZ_W'(hi_q) + SZ_W'(h_q));
			end
			default: begin
			end
		endcase
	end

	lma_sky #(
		.DEPTH(ATLAS_WIDTH),
		.AW   (XW),
		.DW   (HW)
	) u_sky (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(addr_q),
		.rdata(mem_rdata)
	);

	lma_scan #(
		.XW(XW),
		.HW(HW)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.rd_data(mem_rdata),
		.rd_idx (idx_s1),
		.level  (lvl_q),
		.span   (w_q),
		.stat   (scan_stat),
		.pos    (scan_pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			page_q   <= PW'(1);
			w_q      <= '0;
			h_q      <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			lvl_q    <= '0;
			probe_q  <= 1'b0;
			bx_q     <= '0;
			addr_q   <= '0;
			cnt_q    <= '0;
			rd_end_q <= 1'b0;
			vld_s1   <= 1'b0;
			idx_s1   <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= (state_q == S_TEST) && !rd_end_q;
			idx_s1 <= addr_q;
			unique case (state_q)
				S_CLEAR: begin
					if (addr_q == X_LAST) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + XW'(1);
					end
				end
				S_IDLE: begin
					if (start) begin
						w_q <= DIM_W'(req.extent_s >> BLOCK_SHIFT) + DIM_W'(1);
						h_q <= DIM_W'(req.extent_t >> BLOCK_SHIFT) + DIM_W'(1);
						if (req.skip) begin
							done_q   <= 1'b1;
							result_q <= '{status: ST_SKIPPED, x_pos: '0, y_pos: '0, page: '0};
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (fits_dims) begin
						lvl_q    <= HW'(SZ_W'(ATLAS_HEIGHT) - SZ_W'(h_q));
						probe_q  <= 1'b1;
						addr_q   <= '0;
						rd_end_q <= 1'b0;
						state_q  <= S_TEST;
					end else begin
						state_q <= S_FAIL;
					end
				end
				S_TEST: begin
					if (!rd_end_q) begin
						if (addr_q == X_SCAN_END) begin
							rd_end_q <= 1'b1;
						end else begin
							addr_q <= addr_q + XW'(1);
						end
					end
					if (scan_stat.done) begin
						probe_q <= 1'b0;
						if (scan_stat.found) begin
							hi_q    <= lvl_q;
							bx_q    <= scan_pos;
							state_q <= S_NEXT;
							if (probe_q) begin
								lo_q <= '0;
							end
						end else if (probe_q) begin
							state_q <= S_FAIL;
						end else begin
							lo_q    <= lvl_q + HW'(1);
							state_q <= S_NEXT;
						end
					end
				end
				S_NEXT: begin
					if (lo_q == hi_q) begin
						cnt_q   <= '0;
						state_q <= S_RAISE;
					end else begin
						lvl_q    <= mid;
						addr_q   <= '0;
						rd_end_q <= 1'b0;
						state_q  <= S_TEST;
					end
				end
				S_RAISE: begin
					cnt_q <= cnt_q + DIM_W'(1);
					if (cnt_q == w_q - DIM_W'(1)) begin
						done_q   <= 1'b1;
						result_q <= '{status: ST_PLACED, x_pos: OUT_W'(bx_q),
							y_pos: OUT_W'(hi_q), page: OUT_W'(page_q)};
						state_q  <= S_IDLE;
					end
				end
				S_FAIL: begin
					if (pages_out) begin
						done_q   <= 1'b1;
						result_q <= '{status: ST_EXHAUSTED, x_pos: '0, y_pos: '0, page: '0};
						state_q  <= S_IDLE;
					end else if (!fits_dims) begin
						done_q   <= 1'b1;
						result_q <= '{status: ST_TOO_BIG, x_pos: '0, y_pos: '0, page: '0};
						state_q  <= S_IDLE;
					end else begin
						page_q  <= page_q + PW'(1);
						addr_q  <= '0;
						state_q <= S_PAGE;
					end
				end
				S_PAGE: begin
					if (addr_q == X_LAST) begin
						addr_q   <= '0;
						done_q   <= 1'b1;
						result_q <= '{status: ST_PLACED, x_pos: '0, y_pos: '0,
							page: OUT_W'(page_q)};
						state_q  <= S_IDLE;
					end else begin
						addr_q <= addr_q + XW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	`LMA_ALWAYS(a_page_nonzero, page_q != '0, "page counter left its range")
	`LMA_SAME(a_fail_fields_zero, done && result.status != ST_PLACED, result.x_pos == '0 && result.y_pos == '0 && result.page == '0, "non-placed beat carries position data")
	`LMA_NEXT(a_busy_after_start, start && !busy && !req.skip, busy, "placement request not taken up")

endmodule

// ===== bench/lightmap_atlas_allocator_check.sv =====
// Checker for the lightmap atlas allocator: watches the request and result beats,
// keeps its own skyline and page state, and compares every result field by field.
// Depends on lma_pkg for the beat types and status codes.
module lightmap_atlas_allocator_check import lma_pkg::*; #(
	parameter int ATLAS_W = 128,
	parameter int ATLAS_H = 128,
	parameter int PAGES   = 128
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  lma_req_t req,
	input  logic     done,
	input  lma_res_t result,
	output int       pending,
	output int       failures,
	output int       placed_cnt,
	output int       skipped_cnt,
	output int       exhausted_cnt,
	output int       too_big_cnt,
	output int       page_turns
);
	timeunit 1ns;
	timeprecision 1ps;

	int       skyline[ATLAS_W];
	int       cur_page;
	lma_res_t expected_spots[$];
	lma_res_t want;
	int       miss_count;
	int       n_placed, n_skipped, n_exhausted, n_too_big, n_turns;

	assign failures      = miss_count;
	assign placed_cnt    = n_placed;
	assign skipped_cnt   = n_skipped;
	assign exhausted_cnt = n_exhausted;
	assign too_big_cnt   = n_too_big;
	assign page_turns    = n_turns;

	function automatic lma_res_t place_surface(lma_req_t r);
		int       w, h, best, bx, top, s, k;
		bit       ok;
		lma_res_t res;
		res = '0;
		w = (int'(r.extent_s) >> BLOCK_SHIFT) + 1;
		h = (int'(r.extent_t) >> BLOCK_SHIFT) + 1;
		if (r.skip) begin
			res.status = ST_SKIPPED;
			return res;
		end
		best = ATLAS_H;
		bx = 0;
		for (s = 0; s + w < ATLAS_W; s++) begin
			ok = 1'b1;
			top = 0;
			for (k = 0; k < w && ok; k++) begin
				if (skyline[s + k] >= best)
					ok = 1'b0;
				else if (skyline[s + k] > top)
					top = skyline[s + k];
			end
			if (ok) begin
				bx = s;
				best = top;
			end
		end
		if (best + h <= ATLAS_H) begin
			for (k = 0; k < w && bx + k < ATLAS_W; k++)
				skyline[bx + k] = best + h;
			res.status = ST_PLACED;
			res.x_pos  = OUT_W'(bx);
			res.y_pos  = OUT_W'(best);
			res.page   = OUT_W'(cur_page);
		end else if (cur_page + 1 >= PAGES) begin
			res.status = ST_EXHAUSTED;
		end else if (w >= ATLAS_W || h > ATLAS_H) begin
			res.status = ST_TOO_BIG;
		end else begin
			cur_page++;
			n_turns++;
			foreach (skyline[i])
				skyline[i] = (i < w) ? h : 0;
			res.status = ST_PLACED;
			res.page   = OUT_W'(cur_page);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (skyline[i])
				skyline[i] = 0;
			cur_page = 1;
			expected_spots.delete();
			miss_count = 0;
			n_placed = 0;
			n_skipped = 0;
			n_exhausted = 0;
			n_too_big = 0;
			n_turns = 0;
			pending <= 0;
		end else begin
			if (done === 1'b1) begin
				if (expected_spots.size() == 0) begin
					if (miss_count < 10)
						$display("%0t: result beat with nothing expected: status=%0d x=%0d y=%0d page=%0d",
							$realtime, result.status, result.x_pos, result.y_pos, result.page);
					miss_count++;
				end else begin
					want = expected_spots.pop_front();
					if (result.status !== want.status || result.x_pos !== want.x_pos ||
							result.y_pos !== want.y_pos || result.page !== want.page) begin
						if (miss_count < 10)
							$display("%0t: mismatch exp status=%0d x=%0d y=%0d page=%0d, got status=%0d x=%0d y=%0d page=%0d",
								$realtime, want.status, want.x_pos, want.y_pos, want.page,
								result.status, result.x_pos, result.y_pos, result.page);
						miss_count++;
					end
				end
			end else if (done !== 1'b0) begin
				if (miss_count < 10)
					$display("%0t: done strobe is unknown", $realtime);
				miss_count++;
			end
			if (start && busy === 1'b0) begin
				want = place_surface(req);
				case (want.status)
					ST_PLACED:    n_placed++;
					ST_SKIPPED:   n_skipped++;
					ST_EXHAUSTED: n_exhausted++;
					ST_TOO_BIG:   n_too_big++;
				endcase
				expected_spots.push_back(want);
			end
			pending <= expected_spots.size();
		end
	end

endmodule

// ===== bench/lightmap_atlas_allocator_test.sv =====
// Top of the lightmap atlas allocator bench: clock, reset, request stimulus and verdict.
// Depends on lma_pkg, the allocator RTL and lightmap_atlas_allocator_check.
module lightmap_atlas_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lma_pkg::*;

	localparam int ATLAS_W      = 128;
	localparam int ATLAS_H      = 128;
	localparam int PAGES        = 128;
	localparam int RANDOM_ITEMS = 1035;
	localparam int CALM_TAIL    = 120;
	localparam int DRAIN_CYCLES = 1500;
	localparam int LIMIT_CYCLES = 8_000_000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	lma_req_t req = '0;
	logic     busy;
	logic     done;
	lma_res_t result;

	int pending, failures, placed_cnt, skipped_cnt, exhausted_cnt, too_big_cnt, page_turns;
	int cycles = 0;
	int sent = 0;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	lightmap_atlas_allocator #(
		.ATLAS_WIDTH (ATLAS_W),
		.ATLAS_HEIGHT(ATLAS_H),
		.PAGE_COUNT  (PAGES)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.result(result)
	);

	lightmap_atlas_allocator_check #(
		.ATLAS_W(ATLAS_W),
		.ATLAS_H(ATLAS_H),
		.PAGES  (PAGES)
	) placement_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.done         (done),
		.result       (result),
		.pending      (pending),
		.failures     (failures),
		.placed_cnt   (placed_cnt),
		.skipped_cnt  (skipped_cnt),
		.exhausted_cnt(exhausted_cnt),
		.too_big_cnt  (too_big_cnt),
		.page_turns   (page_turns)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic lma_req_t surface(int es, int et, bit sk);
		lma_req_t r;
		r.extent_s = EXT_W'(es);
		r.extent_t = EXT_W'(et);
		r.skip     = sk;
		return r;
	endfunction

	// mostly small to mid-sized surfaces, some skipped, a share of big ones that turn pages, some too wide
	function automatic lma_req_t random_surface();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			return surface($urandom_range(0, 2047), $urandom_range(0, 2047), 1'b1);
		else if (pick < 57)
			return surface($urandom_range(0, 127), $urandom_range(0, 255), 1'b0);
		else if (pick < 75)
			return surface($urandom_range(0, 1023), $urandom_range(0, 1023), 1'b0);
		else if (pick < 87)
			return surface($urandom_range(1024, 2031), $urandom_range(1024, 2047), 1'b0);
		else if (pick < 91)
			return surface($urandom_range(2032, 2047), $urandom_range(0, 2047), 1'b0);
		else
			return surface($urandom_range(0, 2047), $urandom_range(0, 2047), 1'b0);
	endfunction

	task automatic send_beat(lma_req_t r);
		start <= 1'b1;
		req   <= r;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sent++;
	endtask

	task automatic wait_all_back();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	initial begin
		lma_req_t directed[$];
		int       i;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(surface(0, 0, 1'b0));
		directed.push_back(surface(15, 15, 1'b0));
		directed.push_back(surface(16, 16, 1'b0));
		directed.push_back(surface(2047, 2047, 1'b1));
		directed.push_back(surface(0, 0, 1'b1));
		directed.push_back(surface(2047, 0, 1'b0));
		directed.push_back(surface(2032, 2047, 1'b0));
		directed.push_back(surface(2031, 0, 1'b0));
		directed.push_back(surface(0, 2047, 1'b0));
		directed.push_back(surface(2031, 2047, 1'b0));
		directed.push_back(surface(0, 0, 1'b0));
		directed.push_back(surface(1024, 1024, 1'b0));
		directed.push_back(surface(1023, 2047, 1'b0));
		directed.push_back(surface(1365, 682, 1'b0));
		directed.push_back(surface(127, 127, 1'b0));
		directed.push_back(surface(0, 1008, 1'b0));
		directed.push_back(surface(1365, 1365, 1'b0));
		directed.push_back(surface(682, 1365, 1'b0));
		directed.push_back(surface(2047, 2047, 1'b0));
		foreach (directed[k])
			send_beat(directed[k]);
		wait_all_back();

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			send_beat(random_surface());
			if (i == RANDOM_ITEMS / 2)
				wait_all_back();
			else if (i < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		wait_all_back();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests: %0d placed, %0d skipped, %0d refused for no pages, %0d too big",
			sent, placed_cnt, skipped_cnt, exhausted_cnt, too_big_cnt);
		$display("%0d page turns, %0d mismatches, %0d cycles", page_turns, failures, cycles);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
